// File: rtl/arxpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARX permutation cipher package
// Shared types, constants and the round function of the 4x32 ARX block core.
// ----------------------------------------------------------------------------
package arxpc_pkg;

  localparam int ROUND_COUNT_DEF = 20;
  localparam int KEY_REG_COUNT   = 6;
  localparam int KEY_REG_W       = 64;
  localparam int CFG_INDEX_W     = $clog2(KEY_REG_COUNT);
  localparam int QUEUE_DEPTH     = 2;

  localparam int ROT_0 = 1;
  localparam int ROT_1 = 10;
  localparam int ROT_2 = 19;
  localparam int ROT_3 = 28;

  typedef logic [31:0] word_t;
  typedef word_t [3:0] block_t;
  typedef logic [KEY_REG_W-1:0] key_reg_t;

  typedef struct packed {
    logic   keyed;
    block_t blk;
  } item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_HOLD
  } bk_state_t;

  function automatic word_t rotl(input word_t x, input int r);
    rotl = (x << r) | (x >> (32 - r));
  endfunction

  function automatic block_t arx_step(input block_t w, input int ia, input int ib,
                                      input int ic, input int id, input int r);
    block_t o;
    word_t  t;
    o = w;
    t = ((o[ib] ^ o[ic]) & o[ia]) + o[ic];
    o[ib] = rotl(t, r);
    o[id] = o[id] ^ o[ib];
    o[ia] = o[ia] + o[id];
    arx_step = o;
  endfunction

  function automatic block_t arx_round(input block_t w);
    block_t o;
    o = arx_step(w, 0, 1, 2, 3, ROT_0);
    o = arx_step(o, 1, 2, 3, 0, ROT_1);
    o = arx_step(o, 2, 3, 0, 1, ROT_2);
    o = arx_step(o, 3, 0, 1, 2, ROT_3);
    arx_round = o;
  endfunction

endpackage

// File: rtl/arx_permutation_cipher_4x32_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARX permutation cipher, 4x32 top level
// Unkeyed ARX permutation or keyed encryption of one 128-bit block per word.
// ----------------------------------------------------------------------------
// Input side looks like a queue: a word (kind and four block words) is taken
// when in_push is high and in_full is low. The result side is read like a
// queue: the oldest result is on out_word0..3 while out_empty is low and is
// taken when out_pop is high.
// The front stage registers the word and applies the first key whitening,
// a two-entry queue decouples it from the round engine, which runs one round
// per cycle on a single shared round unit.
// Kind 0 words pass through the ROUND_COUNT rounds once and kind 1 words
// twice, with the second key whitening between the passes and the third
// after them; the engine takes a new block from the queue only once the
// last one has gone to the output register. Key registers are written
// through cfg_we, cfg_index and cfg_data; indexes beyond the last key
// register are ignored.
// Reset clears the key registers and empties all stages. When the receiver
// stalls, one result waits in the output register, the engine holds the next
// and the queue and front stage fill before in_full rises.
// ----------------------------------------------------------------------------
module arx_permutation_cipher_4x32_top #(
  parameter int ROUND_COUNT = arxpc_pkg::ROUND_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic                              in_kind,
  input  logic [31:0]                       in_word0,
  input  logic [31:0]                       in_word1,
  input  logic [31:0]                       in_word2,
  input  logic [31:0]                       in_word3,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [31:0]                       out_word0,
  output logic [31:0]                       out_word1,
  output logic [31:0]                       out_word2,
  output logic [31:0]                       out_word3,
  input  logic                              cfg_we,
  input  logic [arxpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [arxpc_pkg::KEY_REG_W-1:0]   cfg_data
);

  arxpc_pkg::key_reg_t key_r [arxpc_pkg::KEY_REG_COUNT];
  arxpc_pkg::block_t   key_grp [3];
  arxpc_pkg::block_t   in_blk, out_blk;
  arxpc_pkg::item_t    fq_data, qb_data;
  logic                q_push, q_full, q_pop, q_empty;

  always_comb begin
    for (int g = 0; g < 3; g++) begin
      key_grp[g][0] = key_r[2*g][31:0];
      key_grp[g][1] = key_r[2*g][63:32];
      key_grp[g][2] = key_r[2*g+1][31:0];
      key_grp[g][3] = key_r[2*g+1][63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < arxpc_pkg::KEY_REG_COUNT; i++) begin
        key_r[i] <= '0;
      end
    end else if (cfg_we && (cfg_index < arxpc_pkg::CFG_INDEX_W'(arxpc_pkg::KEY_REG_COUNT))) begin
      key_r[cfg_index] <= cfg_data;
    end
  end

  assign in_blk[0] = in_word0;
  assign in_blk[1] = in_word1;
  assign in_blk[2] = in_word2;
  assign in_blk[3] = in_word3;

  assign out_word0 = out_blk[0];
  assign out_word1 = out_blk[1];
  assign out_word2 = out_blk[2];
  assign out_word3 = out_blk[3];

  arxpc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_kind  (in_kind),
    .in_blk   (in_blk),
    .key_grp0 (key_grp[0]),
    .q_push   (q_push),
    .q_full   (q_full),
    .q_data   (fq_data)
  );

  arxpc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .full    (q_full),
    .wr_data (fq_data),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (qb_data)
  );

  arxpc_back #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (qb_data),
    .q_pop     (q_pop),
    .key_grp1  (key_grp[1]),
    .key_grp2  (key_grp[2]),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_blk   (out_blk)
  );

endmodule

// File: rtl/arxpc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARX cipher front stage
// Accepts input words, applies the first key whitening for keyed words and
// hands them to the work queue.
// ----------------------------------------------------------------------------
module arxpc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic                in_kind,
  input  arxpc_pkg::block_t   in_blk,
  input  arxpc_pkg::block_t   key_grp0,
  output logic                q_push,
  input  logic                q_full,
  output arxpc_pkg::item_t    q_data
);

  logic              fr_valid_r, fr_valid_nxt;
  arxpc_pkg::item_t  fr_item_r, fr_item_nxt;
  logic              load;

  assign in_full = fr_valid_r && q_full;
  assign load    = in_push && !in_full;
  assign q_push  = fr_valid_r && !q_full;
  assign q_data  = fr_item_r;

  always_comb begin
    fr_valid_nxt = load || (fr_valid_r && q_full);
    fr_item_nxt  = fr_item_r;
    if (load) begin
      fr_item_nxt.keyed = in_kind;
      fr_item_nxt.blk   = in_kind ? (in_blk ^ key_grp0) : in_blk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
    fr_item_r <= fr_item_nxt;
  end

endmodule

// File: rtl/arxpc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARX cipher work queue
// Short first-in first-out queue between the front stage and the round engine.
// ----------------------------------------------------------------------------
module arxpc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  arxpc_pkg::item_t  wr_data,
  input  logic              pop,
  output logic              empty,
  output arxpc_pkg::item_t  rd_data
);

  localparam int DEPTH = arxpc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  arxpc_pkg::item_t   mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full    = cnt_r == CNT_W'(DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: rtl/arxpc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARX cipher round engine
// Runs one round per cycle on a shared round unit, applies the later key
// whitenings and holds the finished block in an output register.
// ----------------------------------------------------------------------------
module arxpc_back #(
  parameter int ROUND_COUNT = arxpc_pkg::ROUND_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  arxpc_pkg::item_t   q_data,
  output logic               q_pop,
  input  arxpc_pkg::block_t  key_grp1,
  input  arxpc_pkg::block_t  key_grp2,
  output logic               out_empty,
  input  logic               out_pop,
  output arxpc_pkg::block_t  out_blk
);

  localparam int CNT_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;

  arxpc_pkg::bk_state_t state_r, state_nxt;
  arxpc_pkg::block_t    blk_r, blk_nxt;
  arxpc_pkg::block_t    round_blk, fin_blk, out_data;
  arxpc_pkg::block_t    out_blk_r, out_blk_nxt;
  logic                 keyed_r, keyed_nxt;
  logic                 pass_r, pass_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free, out_load, last;

  assign round_blk = arxpc_pkg::arx_round(blk_r);
  assign fin_blk   = keyed_r ? (round_blk ^ key_grp2) : round_blk;
  assign last      = cnt_r == CNT_W'(ROUND_COUNT - 1);
  assign out_free  = !out_valid_r || out_pop;
  assign out_empty = !out_valid_r;
  assign out_blk   = out_blk_r;

  always_comb begin
    state_nxt = state_r;
    blk_nxt   = blk_r;
    keyed_nxt = keyed_r;
    pass_nxt  = pass_r;
    cnt_nxt   = cnt_r;
    q_pop     = 1'b0;
    out_load  = 1'b0;
    out_data  = blk_r;
    case (state_r)
      arxpc_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          blk_nxt   = q_data.blk;
          keyed_nxt = q_data.keyed;
          pass_nxt  = 1'b0;
          cnt_nxt   = '0;
          state_nxt = arxpc_pkg::BK_RUN;
        end
      end
      arxpc_pkg::BK_RUN: begin
        blk_nxt = round_blk;
        cnt_nxt = cnt_r + 1'b1;
        if (last) begin
          cnt_nxt = '0;
          if (keyed_r && !pass_r) begin
            blk_nxt  = round_blk ^ key_grp1;
            pass_nxt = 1'b1;
          end else begin
            blk_nxt = fin_blk;
            if (out_free) begin
              out_load  = 1'b1;
              out_data  = fin_blk;
              state_nxt = arxpc_pkg::BK_IDLE;
            end else begin
              state_nxt = arxpc_pkg::BK_HOLD;
            end
          end
        end
      end
      arxpc_pkg::BK_HOLD: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_data  = blk_r;
          state_nxt = arxpc_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = arxpc_pkg::BK_IDLE;
      end
    endcase
    out_valid_nxt = out_load || (out_valid_r && !out_pop);
    out_blk_nxt   = out_load ? out_data : out_blk_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= arxpc_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      pass_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      pass_r      <= pass_nxt;
    end
    blk_r     <= blk_nxt;
    keyed_r   <= keyed_nxt;
    out_blk_r <= out_blk_nxt;
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the 4x32 ARX permutation cipher
// Pushes unkeyed and keyed blocks through the input queue under several key
// settings, with random idle bursts on both sides. Every result word is
// checked, word by word, against a scoreboard that computes each block itself.
// ----------------------------------------------------------------------------
module testbench;
  import arxpc_pkg::*;

  localparam int   ROUNDS        = ROUND_COUNT_DEF;
  localparam logic KIND_PERM     = 1'b0;
  localparam logic KIND_KEYED    = 1'b1;
  localparam int   MAX_REPORTS   = 10;
  localparam int   RANDOM_PHASES = 6;
  localparam int   PHASE_ITEMS   = 135;
  localparam int   TAIL_ITEMS    = 140;

  class cipher_scoreboard;
    key_reg_t keys [KEY_REG_COUNT];
    block_t   expected_q [$];
    int       mismatches;

    function new();
      foreach (keys[i]) keys[i] = '0;
      mismatches = 0;
    endfunction

    function void set_key(int idx, key_reg_t val);
      if (idx < KEY_REG_COUNT) keys[idx] = val;
    endfunction

    function word_t rot_left(word_t x, int r);
      logic [63:0] dbl;
      dbl = {x, x} << r;
      return dbl[63:32];
    endfunction

    function block_t permute(block_t s);
      int     rot [4];
      block_t w;
      word_t  t;
      int     ia, ib, ic, id;
      rot = '{ROT_0, ROT_1, ROT_2, ROT_3};
      w = s;
      for (int n = 0; n < ROUNDS; n++) begin
        for (int j = 0; j < 4; j++) begin
          ia = j;
          ib = (j + 1) % 4;
          ic = (j + 2) % 4;
          id = (j + 3) % 4;
          t = ((w[ib] ^ w[ic]) & w[ia]) + w[ic];
          w[ib] = rot_left(t, rot[j]);
          w[id] = w[id] ^ w[ib];
          w[ia] = w[ia] + w[id];
        end
      end
      return w;
    endfunction

    function block_t whiten(block_t s, int group);
      block_t   w;
      key_reg_t k;
      w = s;
      for (int i = 0; i < 4; i++) begin
        k = keys[(group * 4 + i) / 2];
        w[i] = w[i] ^ (((i % 2) == 1) ? k[63:32] : k[31:0]);
      end
      return w;
    endfunction

    function void note_input(logic kind, block_t blk);
      block_t s;
      s = blk;
      if (kind == KIND_KEYED) begin
        s = whiten(s, 0);
        s = permute(s);
        s = whiten(s, 1);
        s = permute(s);
        s = whiten(s, 2);
      end else begin
        s = permute(s);
      end
      expected_q.push_back(s);
    endfunction

    function void check_result(block_t got);
      block_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Result block %h arrived with none expected", got);
        return;
      end
      want = expected_q.pop_front();
      for (int i = 0; i < 4; i++) begin
        if (got[i] !== want[i]) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("Result word %0d: expected %h, actual %h", i, want[i], got[i]);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_push;
  logic                   in_full;
  logic                   in_kind;
  logic [31:0]            in_word0;
  logic [31:0]            in_word1;
  logic [31:0]            in_word2;
  logic [31:0]            in_word3;
  logic                   out_empty;
  logic                   out_pop;
  logic [31:0]            out_word0;
  logic [31:0]            out_word1;
  logic [31:0]            out_word2;
  logic [31:0]            out_word3;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [KEY_REG_W-1:0]   cfg_data;

  cipher_scoreboard sb;
  key_reg_t         key_plan [KEY_REG_COUNT];
  bit               tx_idle_on;
  bit               rx_idle_on;

  arx_permutation_cipher_4x32_top #(
    .ROUND_COUNT(ROUNDS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_kind  (in_kind),
    .in_word0 (in_word0),
    .in_word1 (in_word1),
    .in_word2 (in_word2),
    .in_word3 (in_word3),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_word0(out_word0),
    .out_word1(out_word1),
    .out_word2(out_word2),
    .out_word3(out_word3),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic word_t rand_word();
    int unsigned bitpos;
    bitpos = $urandom_range(0, 31);
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1 << bitpos;
      3: return ~(32'h1 << bitpos);
      default: return $urandom;
    endcase
  endfunction

  function automatic block_t rand_block();
    return {rand_word(), rand_word(), rand_word(), rand_word()};
  endfunction

  function automatic key_reg_t rand_key();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {rand_word(), rand_word()};
    endcase
  endfunction

  task automatic push_block(input logic kind, input block_t blk);
    if (tx_idle_on && $urandom_range(0, 2) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_push  <= 1'b1;
    in_kind  <= kind;
    in_word0 <= blk[0];
    in_word1 <= blk[1];
    in_word2 <= blk[2];
    in_word3 <= blk[3];
    do @(posedge clk); while (in_full);
    sb.note_input(kind, blk);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_key(input int idx, input key_reg_t val);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_INDEX_W'(idx);
    cfg_data  <= val;
    @(posedge clk);
    sb.set_key(idx, val);
  endtask

  task automatic load_keys(input bit stray);
    for (int i = 0; i < KEY_REG_COUNT; i++) write_key(i, key_plan[i]);
    if (stray) begin
      write_key(KEY_REG_COUNT, rand_key());
      write_key(KEY_REG_COUNT + 1, rand_key());
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int stall;
    stall = 0;
    out_pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty)
        sb.check_result({out_word3, out_word2, out_word1, out_word0});
      if (stall > 0)
        stall--;
      else if (rx_idle_on && $urandom_range(0, 3) == 0)
        stall = $urandom_range(1, 11);
      out_pop <= (stall == 0);
    end
  end

  initial begin
    sb = new();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    rst_n     <= 1'b0;
    in_push   <= 1'b0;
    in_kind   <= KIND_PERM;
    in_word0  <= '0;
    in_word1  <= '0;
    in_word2  <= '0;
    in_word3  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Keys as left by reset.
    push_block(KIND_PERM, {4{32'h0000_0000}});
    push_block(KIND_PERM, {4{32'hFFFF_FFFF}});
    push_block(KIND_KEYED, {4{32'h0000_0000}});
    push_block(KIND_KEYED, {4{32'hFFFF_FFFF}});
    push_block(KIND_PERM, {4{32'hAAAA_AAAA}});
    push_block(KIND_KEYED, {4{32'h5555_5555}});
    drain();

    // All-ones keys, then writes to indexes past the last register.
    foreach (key_plan[i]) key_plan[i] = '1;
    load_keys(1'b1);
    push_block(KIND_KEYED, {4{32'h0000_0000}});
    push_block(KIND_KEYED, {4{32'hFFFF_FFFF}});
    push_block(KIND_PERM, {32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 32'h0000_0001});
    push_block(KIND_KEYED, {32'h0000_0001, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000});
    push_block(KIND_KEYED, {32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555});
    drain();

    foreach (key_plan[i]) key_plan[i] = {rand_word(), rand_word()};
    load_keys(1'b1);
    push_block(KIND_KEYED, {4{32'h0000_0000}});
    push_block(KIND_KEYED, {32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001});
    push_block(KIND_KEYED, {32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h0000_0001});
    push_block(KIND_PERM, {32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000});
    push_block(KIND_KEYED, {32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210});

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      foreach (key_plan[i]) key_plan[i] = (p == 0) ? '0 : rand_key();
      load_keys(1'(p % 2));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 25 == 0) begin
          tx_idle_on = ($urandom_range(0, 2) != 0);
          rx_idle_on = ($urandom_range(0, 2) != 0);
        end
        push_block(1'($urandom_range(0, 1)), rand_block());
      end
    end

    drain();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    foreach (key_plan[i]) key_plan[i] = {rand_word(), rand_word()};
    load_keys(1'b0);
    for (int n = 0; n < TAIL_ITEMS; n++) push_block(1'($urandom_range(0, 1)), rand_block());

    drain();
    repeat (2 * ROUNDS + 8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
